@@ rtl/core/cfp_pkg.sv @@
// Package for the command frame parser.
// Holds the payload structs, the controller/datapath interface structs and frame constants.
// No dependencies.
package cfp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hAA;
    localparam logic [7:0] END_BYTE  = 8'h55;
    localparam logic [7:0] KIND_MOVE = 8'h01;
    localparam logic [7:0] KIND_MODE = 8'h02;
    localparam logic [2:0] LEN_MOVE  = 3'd6;
    localparam logic [2:0] LEN_MODE  = 3'd5;
    localparam int         WIN_DEPTH = 6;

    // Decision codes for the head of the window.
    localparam logic [1:0] ACT_WAIT    = 2'd0;
    localparam logic [1:0] ACT_DROP1   = 2'd1;
    localparam logic [1:0] ACT_CONSUME = 2'd2;

    localparam logic FRAME_KIND_MOVE = 1'b0;
    localparam logic FRAME_KIND_MODE = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_cfp_in;

    typedef struct packed {
        logic              frame_kind;
        logic signed [23:0] turn_cmd;
        logic signed [23:0] speed_cmd;
        logic [7:0]        mode_req;
    } t_cfp_out;

    typedef struct packed {
        logic append;
        logic drop1;
        logic consume;
        logic accept_move;
        logic accept_mode;
        logic mul_turn;
        logic mul_speed;
        logic finish;
        logic load_out;
    } t_cfp_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       kind;
        logic       chk_ok;
    } t_cfp_stat;

endpackage

@@ rtl/core/cfp_datapath.sv @@
// Datapath of the command frame parser: byte window, decision logic, held commands,
// scale register, shared multiplier and output payload register. Uses cfp_pkg.
module cfp_datapath
    import cfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfp_cmd  i_cmd,
    input  t_cfp_in   i_in_data,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_cfp_stat o_stat,
    output t_cfp_out  o_out_data
);

    logic [7:0]  r_win [WIN_DEPTH];
    logic [2:0]  r_fill;
    logic        r_last;
    logic [15:0] r_scale;
    logic [23:0] r_held_turn;
    logic [23:0] r_held_speed;
    logic [7:0]  r_held_mode;
    logic        r_kind;
    logic [7:0]  r_op_turn;
    logic [7:0]  r_op_speed;
    t_cfp_out    r_out;

    logic [2:0]         flen;
    logic               type_ok;
    logic [7:0]         end_byte;
    logic [7:0]         mul_op;
    logic signed [24:0] prod;
    logic [2:0]         n_fill;

    always_comb begin
        type_ok = 1'b1;
        flen    = LEN_MOVE;
        if (r_win[1] == KIND_MOVE) begin
            flen = LEN_MOVE;
        end else if (r_win[1] == KIND_MODE) begin
            flen = LEN_MODE;
        end else begin
            type_ok = 1'b0;
        end
        end_byte = (flen == LEN_MOVE) ? r_win[5] : r_win[4];

        o_stat.kind = (flen == LEN_MODE) ? FRAME_KIND_MODE : FRAME_KIND_MOVE;
        if (flen == LEN_MOVE) begin
            o_stat.chk_ok = (r_win[4] == (KIND_MOVE ^ r_win[2] ^ r_win[3]));
        end else begin
            o_stat.chk_ok = (r_win[3] == (KIND_MODE ^ r_win[2]));
        end

        if (r_fill == 3'd0) begin
            o_stat.act = ACT_WAIT;
        end else if (r_win[0] != HDR_BYTE) begin
            o_stat.act = ACT_DROP1;
        end else if (r_fill < 3'd2) begin
            o_stat.act = ACT_WAIT;
        end else if (!type_ok) begin
            o_stat.act = ACT_DROP1;
        end else if (r_fill < flen) begin
            o_stat.act = ACT_WAIT;
        end else if (end_byte != END_BYTE) begin
            o_stat.act = ACT_DROP1;
        end else begin
            o_stat.act = ACT_CONSUME;
        end
    end

    assign n_fill = (flen >= r_fill) ? 3'd0 : r_fill - flen;
    assign mul_op = i_cmd.mul_turn ? r_op_turn : r_op_speed;
    assign prod   = $signed(mul_op) * $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= 8'h00;
            end
            r_fill       <= 3'd0;
            r_last       <= 1'b0;
            r_scale      <= 16'd1;
            r_held_turn  <= 24'd0;
            r_held_speed <= 24'd0;
            r_held_mode  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_data;
            end
            if (i_cmd.append) begin
                r_last <= i_in_data.chunk_end;
                if (r_fill >= 3'(WIN_DEPTH)) begin
                    // A full window never occurs; drop the oldest byte to stay in bounds.
                    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                        r_win[i] <= r_win[i + 1];
                    end
                    r_win[WIN_DEPTH - 1] <= i_in_data.rx_byte;
                end else begin
                    r_win[r_fill] <= i_in_data.rx_byte;
                    r_fill        <= r_fill + 3'd1;
                end
            end
            if (i_cmd.drop1) begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_fill <= r_fill - 3'd1;
            end
            if (i_cmd.consume) begin
                // Only a six-byte window can keep a byte behind a mode frame.
                if (flen == LEN_MODE) begin
                    r_win[0] <= r_win[5];
                end
                r_fill <= n_fill;
            end
            if (i_cmd.accept_mode) begin
                r_held_mode <= r_win[2];
            end
            if (i_cmd.mul_turn) begin
                r_held_turn <= prod[23:0];
            end
            if (i_cmd.mul_speed) begin
                r_held_speed <= prod[23:0];
            end
            if (i_cmd.finish && r_last) begin
                r_fill <= 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_move) begin
            r_op_turn  <= r_win[2];
            r_op_speed <= r_win[3];
            r_kind     <= FRAME_KIND_MOVE;
        end
        if (i_cmd.accept_mode) begin
            r_kind <= FRAME_KIND_MODE;
        end
        if (i_cmd.load_out) begin
            r_out.frame_kind <= r_kind;
            r_out.turn_cmd   <= r_held_turn;
            r_out.speed_cmd  <= r_held_speed;
            r_out.mode_req   <= r_held_mode;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ rtl/core/cfp_ctrl.sv @@
// Controller of the command frame parser: sequences append, window scan, scaling and emit.
// Uses cfp_pkg; drives the datapath through t_cfp_cmd and reads t_cfp_stat.
module cfp_ctrl
    import cfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_cfp_stat i_stat,
    output t_cfp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MUL_T = 3'd2;
    localparam logic [2:0] ST_MUL_S = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_got, n_got;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_got       = r_got;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.append = 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                case (i_stat.act)
                    ACT_DROP1: begin
                        o_cmd.drop1 = 1'b1;
                    end
                    ACT_CONSUME: begin
                        o_cmd.consume = 1'b1;
                        // A second good frame from the same request would be ignored.
                        if (i_stat.chk_ok && !r_got) begin
                            n_got = 1'b1;
                            if (i_stat.kind == FRAME_KIND_MOVE) begin
                                o_cmd.accept_move = 1'b1;
                                n_state           = ST_MUL_T;
                            end else begin
                                o_cmd.accept_mode = 1'b1;
                            end
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = r_got ? ST_EMIT : ST_IDLE;
                    end
                endcase
            end
            ST_MUL_T: begin
                o_cmd.mul_turn = 1'b1;
                n_state        = ST_MUL_S;
            end
            ST_MUL_S: begin
                o_cmd.mul_speed = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_got          = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_got       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_got       <= n_got;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/command_frame_parser.sv @@
// Top level of the command frame parser: joins the controller and the datapath.
// Depends on cfp_pkg, cfp_ctrl and cfp_datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_cfp_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_cfp_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (speed_scale)
//
// A byte request is appended, then resolved by scan steps (each a head drop or a frame
// consume, with the turn and speed steps of the shared scale multiplier after a move frame)
// and a final check with nothing left; an accepted frame then loads the output register.
// The next byte is taken once the previous one is resolved; a pending result stalls only
// the emit step. Reset is synchronous and sets speed_scale to 1 and clears the window.
// The configuration write is always ready.
module command_frame_parser
    import cfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cfp_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_cfp_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_cfp_cmd  cmd;
    t_cfp_stat stat;

    assign o_cfg_ready = 1'b1;

    cfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cfp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

@@ rtl/core/cfp_checker.sv @@
// Port-level checker for the command frame parser, bound to the top level.
// Depends on cfp_pkg and command_frame_parser.
module cfp_checker
    import cfp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_cfp_out o_out_data
);

    // A byte request always needs scan cycles before the next one is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted byte");

    // Reset leaves the block idle with no result waiting.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ tb/command_frame_parser_test.sv @@
// Self-checking testbench for command_frame_parser: directed frames, then random byte streams.
// Depends on cfp_pkg and the command_frame_parser RTL; expected results come from a local
// frame scanner that runs on every accepted byte request.
module command_frame_parser_test
    import cfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BYTES     = 130;
    localparam int NUM_PHASES      = 6;
    localparam int DIRECTED_COUNT  = 28;

    typedef struct packed {
        t_cfp_in  req;
        logic     typed;        // when set, typed_frame is the expected result
        t_cfp_out typed_frame;
    } t_byte_request;

    localparam t_cfp_out NO_FRAME = '0;

    // Extremes of the signed bytes, a checksum failure, an unknown type followed by a wrong
    // end byte that forces a rescan of buffered bytes, and a frame cut short by a chunk end.
    localparam t_byte_request DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h01, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h7F, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h80, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hFE, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h55, 1'b0}, 1'b1, '{FRAME_KIND_MOVE, 24'sd127, -24'sd128, 8'h00}},
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h02, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hFF, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hFD, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h55, 1'b0}, 1'b1, '{FRAME_KIND_MODE, 24'sd127, -24'sd128, 8'hFF}},
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h02, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h00, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h00, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h55, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h03, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h02, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h02, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h11, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h13, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h55, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'hAA, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h01, 1'b0}, 1'b0, NO_FRAME},
        '{'{8'h05, 1'b1}, 1'b0, NO_FRAME}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_cfp_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_cfp_out    o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    command_frame_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Scanner state, kept in step with the block.
    logic [7:0]         scan_window [WIN_DEPTH];
    int unsigned        scan_fill = 0;
    logic signed [23:0] held_turn = '0;
    logic signed [23:0] held_speed = '0;
    logic [7:0]         held_mode = '0;
    logic [15:0]        scale_setting = 16'd1;

    t_byte_request byte_backlog [$];
    t_cfp_out      expected_frames [$];
    int            error_count = 0;
    int            sender_idle_pct = 0;
    int            receiver_idle_pct = 0;
    int            hold_off_requests = 0;
    int            holds_served = 0;
    int            hold_left = 0;
    int            bytes_queued = 0;

    function automatic void drop_front(int unsigned n);
        if (n >= scan_fill) begin
            scan_fill = 0;
        end else begin
            for (int i = 0; i + n < scan_fill; i++) scan_window[i] = scan_window[i + n];
            scan_fill -= n;
        end
    endfunction

    function automatic logic signed [23:0] scale_byte(logic [7:0] value);
        logic signed [31:0] product;
        product = $signed(value) * $signed({1'b0, scale_setting});
        return product[23:0];
    endfunction

    // Appends one byte, resolves the window from its head and reports an accepted frame.
    function automatic logic parse_byte(t_cfp_in req, output t_cfp_out frame);
        logic       produced;
        logic       scanning;
        logic [2:0] span;
        produced = 1'b0;
        scanning = 1'b1;
        frame = '0;
        if (scan_fill >= WIN_DEPTH) drop_front(1);
        scan_window[scan_fill] = req.rx_byte;
        scan_fill++;
        while (scan_fill > 0 && scanning) begin
            if (scan_window[0] != HDR_BYTE) begin
                drop_front(1);
            end else if (scan_fill < 2) begin
                scanning = 1'b0;
            end else if (scan_window[1] != KIND_MOVE && scan_window[1] != KIND_MODE) begin
                drop_front(1);
            end else begin
                span = (scan_window[1] == KIND_MOVE) ? LEN_MOVE : LEN_MODE;
                if (scan_fill < span) begin
                    scanning = 1'b0;
                end else if (scan_window[span - 1] != END_BYTE) begin
                    drop_front(1);
                end else begin
                    // A frame with a bad checksum is still used up, it just updates nothing.
                    if (span == LEN_MOVE) begin
                        if (scan_window[4] == (KIND_MOVE ^ scan_window[2] ^ scan_window[3])
                                && !produced) begin
                            held_turn = scale_byte(scan_window[2]);
                            held_speed = scale_byte(scan_window[3]);
                            frame.frame_kind = FRAME_KIND_MOVE;
                            produced = 1'b1;
                        end
                    end else if (scan_window[3] == (KIND_MODE ^ scan_window[2]) && !produced) begin
                        held_mode = scan_window[2];
                        frame.frame_kind = FRAME_KIND_MODE;
                        produced = 1'b1;
                    end
                    drop_front(span);
                end
            end
        end
        if (req.chunk_end) scan_fill = 0;
        frame.turn_cmd = held_turn;
        frame.speed_cmd = held_speed;
        frame.mode_req = held_mode;
        return produced;
    endfunction

    task automatic check_frame(t_cfp_out got);
        t_cfp_out want;
        if (expected_frames.size() == 0) begin
            $error("unexpected frame: frame_kind=%0d turn_cmd=%0d speed_cmd=%0d mode_req=%0h",
                   got.frame_kind, got.turn_cmd, got.speed_cmd, got.mode_req);
            error_count++;
        end else begin
            want = expected_frames.pop_front();
            if (got.frame_kind !== want.frame_kind) begin
                $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
                error_count++;
            end
            if (got.turn_cmd !== want.turn_cmd) begin
                $error("turn_cmd: expected %0d, got %0d", want.turn_cmd, got.turn_cmd);
                error_count++;
            end
            if (got.speed_cmd !== want.speed_cmd) begin
                $error("speed_cmd: expected %0d, got %0d", want.speed_cmd, got.speed_cmd);
                error_count++;
            end
            if (got.mode_req !== want.mode_req) begin
                $error("mode_req: expected %0h, got %0h", want.mode_req, got.mode_req);
                error_count++;
            end
        end
    endtask

    // Byte sender: every accepted request is run through the scanner at the same edge.
    always @(posedge i_clk) begin
        t_byte_request next_req;
        t_cfp_out      frame;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                next_req = byte_backlog.pop_front();
                if (parse_byte(next_req.req, frame) || next_req.typed) begin
                    expected_frames.push_back(next_req.typed ? next_req.typed_frame : frame);
                end
            end
            if (!i_in_valid || o_in_ready) begin
                // The head of the backlog stays queued until it is accepted.
                if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= byte_backlog[0].req;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver, with random stalls and an occasional long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_frame(o_out_data);
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_off_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic push_byte(logic [7:0] value, logic last);
        t_byte_request entry;
        entry.req.rx_byte = value;
        entry.req.chunk_end = last;
        entry.typed = 1'b0;
        entry.typed_frame = '0;
        byte_backlog.push_back(entry);
        bytes_queued++;
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly well-formed frames with random content; the rest is noise, bad checksums,
    // wrong end bytes and frames cut short by a chunk end.
    task automatic queue_random_frame();
        logic [7:0]  frame [6];
        int unsigned pick;
        int unsigned len;
        logic        cut_short;
        pick = $urandom_range(99);
        if (pick < 10) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) push_byte(8'($urandom_range(255)),
                                                    $urandom_range(4) == 0);
        end else begin
            frame[0] = HDR_BYTE;
            frame[2] = payload_byte();
            if ($urandom_range(1)) begin
                frame[1] = KIND_MOVE;
                frame[3] = payload_byte();
                frame[4] = KIND_MOVE ^ frame[2] ^ frame[3];
                frame[5] = END_BYTE;
                len = LEN_MOVE;
            end else begin
                frame[1] = KIND_MODE;
                frame[3] = KIND_MODE ^ frame[2];
                frame[4] = END_BYTE;
                len = LEN_MODE;
            end
            if (pick < 18) frame[len - 2] ^= 8'($urandom_range(1, 255));
            else if (pick < 25) frame[len - 1] ^= 8'($urandom_range(1, 255));
            cut_short = (pick >= 25 && pick < 32);
            if (cut_short) len = $urandom_range(1, len - 1);
            for (int i = 0; i < len; i++) begin
                push_byte(frame[i], (i == len - 1) && (cut_short || $urandom_range(9) == 0));
            end
        end
    endtask

    task automatic queue_random_bytes(int count);
        int target;
        target = bytes_queued + count;
        while (bytes_queued < target) queue_random_frame();
    endtask

    // Waits until every request is taken and every frame has come, then lets the block settle.
    task automatic wait_for_idle();
        while (byte_backlog.size() != 0 || i_in_valid || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        scale_setting = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] phase_scale [NUM_PHASES];
        phase_scale = '{16'hFFFF, 16'h0000, 16'($urandom_range(65535)), 16'h0001, 16'h8000,
                        16'($urandom_range(65535))};
        sender_idle_pct = 34;
        receiver_idle_pct = 65;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) byte_backlog.push_back(DIRECTED_ROWS[i]);
        wait_for_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            sender_idle_pct = (phase < 2) ? 34 : (phase < 4) ? 65 : 0;
            receiver_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 34 : 0;
            write_scale(phase_scale[phase]);
            // The long hold-off lets requests pile up so the block must stall its input.
            if (phase == 4) hold_off_requests++;
            queue_random_bytes(PHASE_BYTES);
            wait_for_idle();
        end

        if (error_count == 0) begin
            $display("command_frame_parser_test: done, clean");
        end else begin
            $display("command_frame_parser_test: done, errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("command_frame_parser_test: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cfp_pkg.sv
rtl/core/cfp_datapath.sv
rtl/core/cfp_ctrl.sv
rtl/core/command_frame_parser.sv
rtl/core/cfp_checker.sv
tb/command_frame_parser_test.sv
